/* sv/itp_pkg.sv */
// Shared types, codes and lookup functions of the infix-to-postfix converter.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package itp_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    localparam logic [3:0] CODE_NONE  = 4'd0;
    localparam logic [3:0] CODE_PAREN = 4'd1;
    localparam logic [3:0] CODE_BRACK = 4'd2;
    localparam logic [3:0] CODE_BRACE = 4'd3;
    localparam logic [3:0] CODE_PLUS  = 4'd4;
    localparam logic [3:0] CODE_MINUS = 4'd5;
    localparam logic [3:0] CODE_MUL   = 4'd6;
    localparam logic [3:0] CODE_DIV   = 4'd7;
    localparam logic [3:0] CODE_NEG   = 4'd8;
    localparam logic [3:0] CODE_POS   = 4'd9;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_MISMATCH = 3'd2;
    localparam logic [2:0] ST_UNCLOSED = 3'd3;
    localparam logic [2:0] ST_OVERFLOW = 3'd4;

    typedef struct packed {
        logic [7:0] symbol;
        logic       has_symbol;
        logic       new_token;
        logic [2:0] status;
        logic       end_of_run;
    } res_t;

    function automatic logic [3:0] code_of(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            8'h28:   r = CODE_PAREN;
            8'h5B:   r = CODE_BRACK;
            8'h7B:   r = CODE_BRACE;
            8'h2B:   r = CODE_PLUS;
            8'h2D:   r = CODE_MINUS;
            8'h2A:   r = CODE_MUL;
            8'h2F:   r = CODE_DIV;
            8'h7E:   r = CODE_NEG;
            8'h23:   r = CODE_POS;
            default: r = CODE_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input logic [3:0] code);
        logic [7:0] r;
        case (code)
            CODE_PAREN: r = 8'h28;
            CODE_BRACK: r = 8'h5B;
            CODE_BRACE: r = 8'h7B;
            CODE_PLUS:  r = 8'h2B;
            CODE_MINUS: r = 8'h2D;
            CODE_MUL:   r = 8'h2A;
            CODE_DIV:   r = 8'h2F;
            CODE_NEG:   r = 8'h7E;
            CODE_POS:   r = 8'h23;
            default:    r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [2:0] code_prec(input logic [3:0] code);
        logic [2:0] r;
        case (code) inside
            CODE_PLUS, CODE_MINUS: r = 3'd2;
            CODE_MUL, CODE_DIV:    r = 3'd3;
            CODE_NEG, CODE_POS:    r = 3'd4;
            default:               r = 3'd0;
        endcase
        return r;
    endfunction

    function automatic logic is_open(input logic [3:0] code);
        return (code == CODE_PAREN) || (code == CODE_BRACK) || (code == CODE_BRACE);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == 8'h2E);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [3:0] close_want(input logic [7:0] c);
        logic [3:0] r;
        case (c)
            8'h29:   r = CODE_PAREN;
            8'h5D:   r = CODE_BRACK;
            8'h7D:   r = CODE_BRACE;
            default: r = CODE_NONE;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/itp_stack_ram.sv */
// Operator stack storage: one write port, one registered read port.
// A read of the entry written in the same cycle returns the new data.
`default_nettype none

module itp_stack_ram
    import itp_pkg::*;
#(
    parameter int DEPTH = STACK_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [3:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [3:0]    rdata
);

    logic [3:0] mem [DEPTH];
    logic [3:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/itp_obuf.sv */
// Output register between the converter core and the result channel.
// Depends on itp_pkg for the result word type.
`default_nettype none

module itp_obuf
    import itp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    input  wire res_t in_word,
    output logic      in_ready,
    output logic      out_valid,
    output res_t      out_word,
    input  wire logic out_ready
);

    logic valid_reg;
    res_t word_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            word_reg <= in_word;
        end
    end

endmodule

`default_nettype wire

/* sv/infix_to_postfix_converter_unit.sv */
// Infix-to-postfix converter: shunting-yard over an operator stack in a synchronous RAM.
// One byte per cycle while the output register accepts; a byte that pops an operator waits
// in S_BUSY for the new top from the RAM. After the last byte S_DRAIN pops the rest and
// reports an unclosed bracket, then the run closes; its words are held back one word so the
// final word is marked. Results reach the output register the cycle after they are made.
// Asynchronous reset clears all control state; stack contents stay (no clearing pass).
`default_nettype none

module infix_to_postfix_converter_unit
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_in,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] symbol,
    output logic            has_symbol,
    output logic            new_token,
    output logic      [2:0] status,
    output logic            end_of_run
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(STACK_DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_BUSY  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          expect_reg, expect_next;
    logic          inside_reg, inside_next;
    logic          err_reg, err_next;
    logic          pend_valid_reg, pend_valid_next;
    res_t          pend_reg, pend_next;
    logic [7:0]    char_reg;
    logic          last_reg;

    logic          adv;
    logic          go;
    logic [7:0]    cur_char;
    logic          cur_last;
    logic [3:0]    cur_code;
    logic [3:0]    want;
    logic [3:0]    top;
    logic          top_open;
    logic          full;

    logic          we;
    logic [AW-1:0] waddr;
    logic [3:0]    wdata;
    logic [AW-1:0] raddr;

    logic          put_valid;
    res_t          put_word;
    logic          fin;
    logic          done;
    logic [2:0]    err_st;

    logic          ob_valid;
    res_t          ob_word;
    res_t          out_word;

    assign cur_char = (state_reg == S_IDLE) ? char_in : char_reg;
    assign cur_last = (state_reg == S_IDLE) ? last : last_reg;
    assign cur_code = code_of(cur_char);
    assign want     = close_want(cur_char);
    assign top_open = is_open(top);
    assign full     = (cnt_reg == FULL_CNT);
    assign in_ready = adv && (state_reg == S_IDLE);
    assign go       = adv && ((state_reg != S_IDLE) || in_valid);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        expect_next = expect_reg;
        inside_next = inside_reg;
        err_next    = err_reg;
        we          = 1'b0;
        waddr       = cnt_reg[AW-1:0];
        wdata       = cur_code;
        put_valid   = 1'b0;
        put_word    = '0;
        fin         = 1'b0;
        done        = 1'b1;
        err_st      = ST_OK;

        if (go)
        begin
            unique case (state_reg) inside
                S_IDLE, S_BUSY:
                begin
                    if ((state_reg == S_IDLE) && err_reg)
                    begin
                        fin = cur_last;
                    end
                    else
                    begin
                        if (is_alnum(cur_char))
                        begin
                            put_valid   = 1'b1;
                            put_word    = '{cur_char, 1'b1, !inside_reg, ST_OK, 1'b0};
                            inside_next = 1'b1;
                            expect_next = 1'b0;
                        end
                        else
                        begin
                            inside_next = 1'b0;
                            if (is_space(cur_char))
                            begin
                                done = 1'b1;
                            end
                            else if (want != CODE_NONE)
                            begin
                                if ((cnt_reg != '0) && !top_open)
                                begin
                                    put_valid = 1'b1;
                                    put_word  = '{code_char(top), 1'b1, 1'b1, ST_OK, 1'b0};
                                    cnt_next  = cnt_reg - CW'(1);
                                    done      = 1'b0;
                                end
                                else if ((cnt_reg == '0) || (top != want))
                                begin
                                    err_st = ST_MISMATCH;
                                end
                                else
                                begin
                                    cnt_next    = cnt_reg - CW'(1);
                                    expect_next = 1'b0;
                                end
                            end
                            else if (cur_code == CODE_NONE)
                            begin
                                err_st = ST_INVALID;
                            end
                            else if (is_open(cur_code))
                            begin
                                if (full)
                                begin
                                    err_st = ST_OVERFLOW;
                                end
                                else
                                begin
                                    we          = 1'b1;
                                    cnt_next    = cnt_reg + CW'(1);
                                    expect_next = 1'b1;
                                end
                            end
                            else if (expect_reg &&
                                     ((cur_code == CODE_PLUS) || (cur_code == CODE_MINUS)))
                            begin
                                if (full)
                                begin
                                    err_st = ST_OVERFLOW;
                                end
                                else
                                begin
                                    we       = 1'b1;
                                    wdata    = (cur_code == CODE_MINUS) ? CODE_NEG : CODE_POS;
                                    cnt_next = cnt_reg + CW'(1);
                                end
                            end
                            else if ((cnt_reg != '0) && !top_open &&
                                     (code_prec(top) >= code_prec(cur_code)))
                            begin
                                put_valid = 1'b1;
                                put_word  = '{code_char(top), 1'b1, 1'b1, ST_OK, 1'b0};
                                cnt_next  = cnt_reg - CW'(1);
                                done      = 1'b0;
                            end
                            else if (full)
                            begin
                                err_st = ST_OVERFLOW;
                            end
                            else
                            begin
                                we          = 1'b1;
                                cnt_next    = cnt_reg + CW'(1);
                                expect_next = 1'b1;
                            end
                        end

                        if (!done)
                        begin
                            state_next = S_BUSY;
                        end
                        else if (err_st != ST_OK)
                        begin
                            put_valid = 1'b1;
                            put_word  = '{8'h00, 1'b0, 1'b0, err_st, 1'b0};
                            if (cur_last)
                            begin
                                state_next = S_FLUSH;
                            end
                            else
                            begin
                                err_next   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = cur_last ? S_DRAIN : S_IDLE;
                        end
                    end
                end
                S_DRAIN:
                begin
                    if (cnt_reg == '0)
                    begin
                        fin = 1'b1;
                    end
                    else if (top_open)
                    begin
                        put_valid  = 1'b1;
                        put_word   = '{8'h00, 1'b0, 1'b0, ST_UNCLOSED, 1'b0};
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        put_valid = 1'b1;
                        put_word  = '{code_char(top), 1'b1, 1'b1, ST_OK, 1'b0};
                        cnt_next  = cnt_reg - CW'(1);
                    end
                end
                S_FLUSH:
                begin
                    fin = 1'b1;
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase
        end

        if (fin)
        begin
            cnt_next    = '0;
            expect_next = 1'b1;
            inside_next = 1'b0;
            err_next    = 1'b0;
            state_next  = S_IDLE;
        end
    end

    always_comb
    begin
        ob_valid        = 1'b0;
        ob_word         = put_word;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (fin)
        begin
            ob_valid        = 1'b1;
            ob_word         = pend_valid_reg ? pend_reg
                                             : '{8'h00, 1'b0, 1'b0, ST_OK, 1'b0};
            ob_word.end_of_run = 1'b1;
            pend_valid_next = 1'b0;
        end
        else if (put_valid && cur_last)
        begin
            ob_valid        = pend_valid_reg;
            ob_word         = pend_reg;
            pend_next       = put_word;
            pend_valid_next = 1'b1;
        end
        else if (put_valid)
        begin
            ob_valid = 1'b1;
        end
    end

    always_comb
    begin
        if (cnt_next == '0)
        begin
            raddr = '0;
        end
        else
        begin
            raddr = AW'(cnt_next - CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            expect_reg     <= 1'b1;
            inside_reg     <= 1'b0;
            err_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            expect_reg     <= expect_next;
            inside_reg     <= inside_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (in_ready && in_valid)
        begin
            char_reg <= char_in;
            last_reg <= last;
        end
    end

    itp_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (top)
    );

    itp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ob_valid),
        .in_word   (ob_word),
        .in_ready  (adv),
        .out_valid (out_valid),
        .out_word  (out_word),
        .out_ready (out_ready)
    );

    assign symbol     = out_word.symbol;
    assign has_symbol = out_word.has_symbol;
    assign new_token  = out_word.new_token;
    assign status     = out_word.status;
    assign end_of_run = out_word.end_of_run;

endmodule

`default_nettype wire

/* bench/infix_to_postfix_converter_unit_tb.sv */
// Self-checking bench for the infix-to-postfix converter: directed and random expressions
// streamed byte by byte, postfix words predicted by a scoreboard class and checked in order.
// Depends on itp_pkg and infix_to_postfix_converter_unit.
`timescale 1ns / 1ps

module infix_to_postfix_converter_unit_tb;
    import itp_pkg::*;

    localparam int RANDOM_WORDS = 470;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 80;
    localparam int LIMIT_CYCLES = 800000;
    localparam int MAX_PRINTS   = 25;

    localparam string OPERAND_CHARS = "abqxyzAMQZ0159.";
    localparam string BINARY_OPS    = "+-*/#~";
    localparam string OPEN_CHARS    = "([{";
    localparam string CLOSE_CHARS   = ")]}";

    class postfix_checker;
        logic [3:0] op_stack [STACK_DEPTH_DEF];
        int         stack_used;
        bit         want_operand;
        bit         in_operand;
        bit         run_failed;
        res_t       postfix_due [$];
        res_t       step_words [$];
        int         errors;
        int         words_checked;
        int         status_seen [8];

        function new();
            restart();
            errors = 0;
            words_checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
        endfunction

        function void restart();
            stack_used   = 0;
            want_operand = 1'b1;
            in_operand   = 1'b0;
            run_failed   = 1'b0;
        endfunction

        function logic [3:0] op_code(logic [7:0] c);
            case (c)
                "(":     return CODE_PAREN;
                "[":     return CODE_BRACK;
                "{":     return CODE_BRACE;
                "+":     return CODE_PLUS;
                "-":     return CODE_MINUS;
                "*":     return CODE_MUL;
                "/":     return CODE_DIV;
                "~":     return CODE_NEG;
                "#":     return CODE_POS;
                default: return CODE_NONE;
            endcase
        endfunction

        function logic [7:0] op_glyph(logic [3:0] code);
            case (code)
                CODE_PAREN: return "(";
                CODE_BRACK: return "[";
                CODE_BRACE: return "{";
                CODE_PLUS:  return "+";
                CODE_MINUS: return "-";
                CODE_MUL:   return "*";
                CODE_DIV:   return "/";
                CODE_NEG:   return "~";
                CODE_POS:   return "#";
                default:    return 8'h00;
            endcase
        endfunction

        function int op_rank(logic [3:0] code);
            case (code)
                CODE_PLUS, CODE_MINUS: return 2;
                CODE_MUL, CODE_DIV:    return 3;
                CODE_NEG, CODE_POS:    return 4;
                default:               return 0;
            endcase
        endfunction

        function bit is_bracket(logic [3:0] code);
            return code == CODE_PAREN || code == CODE_BRACK || code == CODE_BRACE;
        endfunction

        function logic [3:0] top_op();
            return op_stack[stack_used - 1];
        endfunction

        function void emit(logic [7:0] sym, logic has, logic first, logic [2:0] st);
            res_t w;
            w.symbol     = sym;
            w.has_symbol = has;
            w.new_token  = first;
            w.status     = st;
            w.end_of_run = 1'b0;
            step_words.push_back(w);
        endfunction

        function void pop_emit();
            emit(op_glyph(top_op()), 1'b1, 1'b1, ST_OK);
            stack_used--;
        endfunction

        function bit push_op(logic [3:0] code);
            if (stack_used >= STACK_DEPTH_DEF)
                return 1'b0;
            op_stack[stack_used] = code;
            stack_used++;
            return 1'b1;
        endfunction

        function logic [2:0] scan_char(logic [7:0] c);
            logic [3:0] code;
            logic [3:0] want;
            if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
                (c >= "a" && c <= "z") || c == ".")
            begin
                emit(c, 1'b1, !in_operand, ST_OK);
                in_operand   = 1'b1;
                want_operand = 1'b0;
                return ST_OK;
            end
            in_operand = 1'b0;
            if (c == " " || (c >= 8'd9 && c <= 8'd13))
                return ST_OK;
            if (c == ")" || c == "]" || c == "}")
            begin
                want = (c == ")") ? CODE_PAREN : (c == "]") ? CODE_BRACK : CODE_BRACE;
                while (stack_used > 0 && !is_bracket(top_op()))
                    pop_emit();
                if (stack_used == 0 || top_op() != want)
                    return ST_MISMATCH;
                stack_used--;
                want_operand = 1'b0;
                return ST_OK;
            end
            code = op_code(c);
            if (code == CODE_NONE)
                return ST_INVALID;
            if (is_bracket(code))
            begin
                if (!push_op(code))
                    return ST_OVERFLOW;
                want_operand = 1'b1;
                return ST_OK;
            end
            if (want_operand && (code == CODE_PLUS || code == CODE_MINUS))
            begin
                if (!push_op(code == CODE_MINUS ? CODE_NEG : CODE_POS))
                    return ST_OVERFLOW;
                return ST_OK;
            end
            while (stack_used > 0 && !is_bracket(top_op()) && op_rank(top_op()) >= op_rank(code))
                pop_emit();
            if (!push_op(code))
                return ST_OVERFLOW;
            want_operand = 1'b1;
            return ST_OK;
        endfunction

        function void absorb_char(logic [7:0] c, logic l);
            logic [2:0] st;
            res_t       w;
            step_words.delete();
            if (!run_failed)
            begin
                st = scan_char(c);
                if (st != ST_OK)
                begin
                    emit(8'h00, 1'b0, 1'b0, st);
                    run_failed = 1'b1;
                end
                else if (l)
                begin
                    while (stack_used > 0)
                    begin
                        if (is_bracket(top_op()))
                        begin
                            emit(8'h00, 1'b0, 1'b0, ST_UNCLOSED);
                            break;
                        end
                        pop_emit();
                    end
                end
            end
            if (l)
            begin
                if (step_words.size() == 0)
                    emit(8'h00, 1'b0, 1'b0, ST_OK);
                w = step_words.pop_back();
                w.end_of_run = 1'b1;
                step_words.push_back(w);
                restart();
            end
            foreach (step_words[i])
            begin
                postfix_due.push_back(step_words[i]);
                status_seen[step_words[i].status]++;
            end
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_word(res_t got);
            res_t want;
            if (postfix_due.size() == 0)
            begin
                report($sformatf("unexpected word symbol=%02h status=%0d",
                                 got.symbol, got.status));
                return;
            end
            want = postfix_due.pop_front();
            words_checked++;
            if (got.symbol !== want.symbol)
                report($sformatf("word %0d symbol %02h, want %02h",
                                 words_checked, got.symbol, want.symbol));
            if (got.has_symbol !== want.has_symbol)
                report($sformatf("word %0d has_symbol %b, want %b",
                                 words_checked, got.has_symbol, want.has_symbol));
            if (got.new_token !== want.new_token)
                report($sformatf("word %0d new_token %b, want %b",
                                 words_checked, got.new_token, want.new_token));
            if (got.status !== want.status)
                report($sformatf("word %0d status %0d, want %0d",
                                 words_checked, got.status, want.status));
            if (got.end_of_run !== want.end_of_run)
                report($sformatf("word %0d end_of_run %b, want %b",
                                 words_checked, got.end_of_run, want.end_of_run));
        endtask
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] char_in   = 8'h00;
    logic       last      = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] symbol;
    logic       has_symbol;
    logic       new_token;
    logic [2:0] status;
    logic       end_of_run;

    postfix_checker scoreboard = new();
    res_t           seen;
    bit             calm       = 1'b0;
    bit             hold_off   = 1'b0;
    int             holds_done = 0;
    int             words_sent = 0;
    int             runs_sent  = 0;
    logic [7:0]     expr_bytes [$];

    infix_to_postfix_converter_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .symbol     (symbol),
        .has_symbol (has_symbol),
        .new_token  (new_token),
        .status     (status),
        .end_of_run (end_of_run)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen = {symbol, has_symbol, new_token, status, end_of_run};
            scoreboard.check_word(seen);
        end
    end

    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_off)
            begin
                hold_off = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            gap = calm ? 0 : $urandom_range(0, 10);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic logic [7:0] pick(string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    function automatic void add_operand();
        int n;
        n = $urandom_range(1, 3);
        repeat (n) expr_bytes.push_back(pick(OPERAND_CHARS));
    endfunction

    function automatic void maybe_space();
        if ($urandom_range(0, 5) == 0)
            expr_bytes.push_back($urandom_range(0, 1) ? 8'd32 : 8'($urandom_range(9, 13)));
    endfunction

    function automatic void add_expr(int depth);
        int terms;
        int k;
        if ($urandom_range(0, 4) == 0)
            expr_bytes.push_back(pick("+-"));
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
            begin
                maybe_space();
                expr_bytes.push_back(pick(BINARY_OPS));
                maybe_space();
                if ($urandom_range(0, 6) == 0)
                    expr_bytes.push_back(pick("+-"));
            end
            if (depth > 0 && $urandom_range(0, 2) == 0)
            begin
                k = $urandom_range(0, 2);
                expr_bytes.push_back(OPEN_CHARS[k]);
                add_expr(depth - 1);
                expr_bytes.push_back(CLOSE_CHARS[k]);
            end
            else
                add_operand();
        end
    endfunction

    function automatic void add_deep_run();
        int n;
        int k;
        bit signs_only;
        int opens [$];
        n = $urandom_range(28, 34);
        signs_only = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < n; i++)
        begin
            if (signs_only || $urandom_range(0, 2) == 0)
                expr_bytes.push_back(pick("+-"));
            else
            begin
                k = $urandom_range(0, 2);
                expr_bytes.push_back(OPEN_CHARS[k]);
                opens.push_front(k);
            end
        end
        add_operand();
        if ($urandom_range(0, 1))
            foreach (opens[i])
                expr_bytes.push_back(CLOSE_CHARS[opens[i]]);
    endfunction

    function automatic void build_random_run();
        int kind;
        int pos;
        int n;
        kind = $urandom_range(0, 99);
        if (kind < 60)
            add_expr($urandom_range(1, 3));
        else if (kind < 72)
            add_deep_run();
        else if (kind < 86)
        begin
            add_expr(2);
            pos = $urandom_range(0, expr_bytes.size() - 1);
            case ($urandom_range(0, 3))
                0: expr_bytes[pos] = pick(")]}([{+*/");
                1: if (expr_bytes.size() > 1) expr_bytes.delete(pos);
                2: expr_bytes.push_back(pick(CLOSE_CHARS));
                default: expr_bytes.insert(pos, pick(OPEN_CHARS));
            endcase
        end
        else
        begin
            n = $urandom_range(1, 8);
            repeat (n) expr_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_word(input logic [7:0] c, input logic l);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        char_in  <= c;
        last     <= l;
        do
            @(posedge clk);
        while (!in_ready);
        scoreboard.absorb_char(c, l);
        words_sent++;
        @(negedge clk);
    endtask

    task automatic send_run();
        for (int i = 0; i < expr_bytes.size(); i++)
            send_word(expr_bytes[i], i == expr_bytes.size() - 1);
        runs_sent++;
    endtask

    task automatic send_text(string s);
        expr_bytes.delete();
        for (int i = 0; i < s.len(); i++)
            expr_bytes.push_back(s[i]);
        send_run();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (scoreboard.postfix_due.size() != 0);
    endtask

    initial
    begin
        int random_words;
        bit hold_fired;
        random_words = 0;
        hold_fired   = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_text("+a-(b*[c.9]/{Z})~y#z");
        send_text("(a]");
        expr_bytes = '{8'hFF, 8'h00};
        send_run();
        send_text("-(");
        expr_bytes = '{8'h09};
        send_run();
        wait_drained();

        while (random_words < RANDOM_WORDS)
        begin
            calm = ($urandom_range(0, 7) == 0);
            if (!hold_fired && random_words >= 150)
            begin
                hold_fired = 1'b1;
                hold_off   = 1'b1;
                calm       = 1'b1;
                while (holds_done == 0)
                begin
                    expr_bytes.delete();
                    add_expr(2);
                    send_run();
                    random_words += expr_bytes.size();
                end
                wait_drained();
            end
            expr_bytes.delete();
            build_random_run();
            send_run();
            random_words += expr_bytes.size();
            if ($urandom_range(0, 11) == 0)
                wait_drained();
        end

        in_valid <= 1'b0;
        while (scoreboard.postfix_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Streamed %0d bytes in %0d expressions; checked %0d postfix words.",
                 words_sent, runs_sent, scoreboard.words_checked);
        $display("Error words: invalid %0d, bracket mismatch %0d, unclosed %0d, overflow %0d.",
                 scoreboard.status_seen[ST_INVALID], scoreboard.status_seen[ST_MISMATCH],
                 scoreboard.status_seen[ST_UNCLOSED], scoreboard.status_seen[ST_OVERFLOW]);
        if (scoreboard.errors == 0 && scoreboard.postfix_due.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
sv/itp_pkg.sv
sv/itp_stack_ram.sv
sv/itp_obuf.sv
sv/infix_to_postfix_converter_unit.sv
bench/infix_to_postfix_converter_unit_tb.sv
